>>> rtl/itpd_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and colour helper functions for the indexed texture pixel decoder.
// No dependencies; imported by the top level.
package itpd_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  localparam logic [1:0] MODE_4BIT   = 2'd0;
  localparam logic [1:0] MODE_8BIT   = 2'd1;
  localparam logic [1:0] MODE_DIRECT = 2'd2;

  localparam logic REG_MODE = 1'b0;
  localparam logic REG_GRAY = 1'b1;

  localparam logic ACT_PAL_WRITE = 1'b0;
  localparam logic ACT_PIXEL     = 1'b1;

  // Each 5-bit channel is widened by appending three zero bits.
  function automatic rgb_t rgb555_expand(input logic [14:0] c);
    rgb_t res;
    res.red   = {c[14:10], 3'b000};
    res.green = {c[9:5], 3'b000};
    res.blue  = {c[4:0], 3'b000};
    return res;
  endfunction

  // 255 - i*255/16, which is 255 at zero and 256 - 16*i otherwise.
  function automatic logic [7:0] gray_ramp16(input logic [3:0] i);
    logic [8:0] d;
    d = 9'd256 - {1'b0, i, 4'b0000};
    return (i == 4'd0) ? 8'hFF : d[7:0];
  endfunction

  // 255 - i*255/256, which is 255 at zero and 256 - i otherwise.
  function automatic logic [7:0] gray_ramp256(input logic [7:0] i);
    logic [8:0] d;
    d = 9'd256 - {1'b0, i};
    return (i == 8'd0) ? 8'hFF : d[7:0];
  endfunction

  function automatic rgb_t gray_rgb(input logic [7:0] g);
    rgb_t res;
    res.red   = g;
    res.green = g;
    res.blue  = g;
    return res;
  endfunction

endpackage

>>> rtl/itpd_ram.sv
`timescale 1ns / 1ps
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module itpd_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_a_r <= mem_r[raddr_a];
      rdata_b_r <= mem_r[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

>>> rtl/indexed_texture_pixel_decoder.sv
`timescale 1ns / 1ps
// Top level: palette store, pixel decode and output register of the texture pixel decoder.
// Depends on itpd_pkg and itpd_ram.
// A pixel item passes the stage-1 register, then the output register, before it is offered.
// Throughput: one item per cycle in 8-bit and direct modes and for palette writes, unless
// the output stalls; in 4-bit mode the result register gives both pixels before a new item.
// Reset (synchronous, active low) restores mode 8-bit and gray palette off, empties the
// pipeline and clears the per-entry valid bits, so every palette entry reads as zero at once.
module indexed_texture_pixel_decoder #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [7:0]  in_palette_index,
  input  logic [15:0] in_data_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_last_of_run,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import itpd_pkg::*;

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam logic [8:0] DEPTH9 = 9'(PALETTE_DEPTH);

  logic [1:0]               mode_r;
  logic                     gray_r;
  logic [PALETTE_DEPTH-1:0] pal_vld_r;
  logic [PALETTE_DEPTH-1:0] pal_vld_nxt;
  logic                     s1_valid_r, s1_valid_nxt;
  logic                     s1_half_r, s1_half_nxt;
  logic [15:0]              s1_word_r;
  logic                     s1_hit_a_r, s1_hit_b_r;
  logic                     out_valid_r, out_valid_nxt;
  rgb_t                     out_rgb_r, out_rgb_nxt;
  logic                     out_last_r, out_last_nxt;

  logic       in_acc, pal_wr, pix_rd, idx_ok;
  logic       cfg_wr;
  logic [7:0] raddr_a8, raddr_b8;
  logic       ok_a, hit_a_nxt, hit_b_nxt;
  logic       out_load, emit, s1_leave;
  logic [14:0] rdata_a, rdata_b;
  logic [3:0]  nib;
  logic        hit_sel;
  logic [14:0] col_sel;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite;
  assign in_acc   = in_valid & in_ready;
  assign idx_ok   = ({1'b0, in_palette_index} < DEPTH9);
  assign pal_wr   = in_acc & (in_action == ACT_PAL_WRITE) & idx_ok;
  assign pix_rd   = in_acc & (in_action == ACT_PIXEL);

  assign raddr_a8 = (mode_r == MODE_4BIT) ? {4'b0000, in_data_word[7:4]} : in_data_word[7:0];
  assign raddr_b8 = {4'b0000, in_data_word[3:0]};
  assign ok_a     = ({1'b0, raddr_a8} < DEPTH9);
  assign hit_a_nxt = ok_a & pal_vld_r[raddr_a8[AW-1:0]];
  assign hit_b_nxt = pal_vld_r[raddr_b8[AW-1:0]];

  itpd_ram #(
    .WIDTH(15),
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk     (clk),
    .we      (pal_wr),
    .waddr   (in_palette_index[AW-1:0]),
    .wdata   (in_data_word[14:0]),
    .re      (pix_rd),
    .raddr_a (raddr_a8[AW-1:0]),
    .raddr_b (raddr_b8[AW-1:0]),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign out_load = !out_valid_r || out_ready;
  assign emit     = s1_valid_r && out_load;
  assign s1_leave = emit && ((mode_r != MODE_4BIT) || s1_half_r);
  assign in_ready = !s1_valid_r || s1_leave;

  always_comb begin
    pal_vld_nxt = pal_vld_r;
    if (pal_wr) begin
      pal_vld_nxt[in_palette_index[AW-1:0]] = 1'b1;
    end
    s1_valid_nxt = pix_rd ? 1'b1 : (s1_leave ? 1'b0 : s1_valid_r);
    s1_half_nxt  = s1_half_r;
    if (pix_rd) begin
      s1_half_nxt = 1'b0;
    end else if (emit && (mode_r == MODE_4BIT) && !s1_half_r) begin
      s1_half_nxt = 1'b1;
    end
    out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_comb begin
    nib     = s1_half_r ? s1_word_r[3:0] : s1_word_r[7:4];
    hit_sel = s1_half_r ? s1_hit_b_r : s1_hit_a_r;
    col_sel = s1_half_r ? rdata_b : rdata_a;
    out_last_nxt = (mode_r != MODE_4BIT) || s1_half_r;
    case (mode_r)
      MODE_4BIT: begin
        if (gray_r) begin
          out_rgb_nxt = gray_rgb(gray_ramp16(nib));
        end else begin
          out_rgb_nxt = hit_sel ? rgb555_expand(col_sel) : '0;
        end
      end
      MODE_8BIT: begin
        if (gray_r) begin
          out_rgb_nxt = gray_rgb(gray_ramp256(s1_word_r[7:0]));
        end else begin
          out_rgb_nxt = s1_hit_a_r ? rgb555_expand(rdata_a) : '0;
        end
      end
      default: begin
        out_rgb_nxt = rgb555_expand(s1_word_r[14:0]);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_8BIT;
      gray_r      <= 1'b0;
      pal_vld_r   <= '0;
      s1_valid_r  <= 1'b0;
      s1_half_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (paddr[2])
          REG_MODE: mode_r <= pwdata[1:0];
          REG_GRAY: gray_r <= pwdata[0];
          default:  mode_r <= mode_r;
        endcase
      end
      pal_vld_r   <= pal_vld_nxt;
      s1_valid_r  <= s1_valid_nxt;
      s1_half_r   <= s1_half_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_rd) begin
      s1_word_r  <= in_data_word;
      s1_hit_a_r <= hit_a_nxt;
      s1_hit_b_r <= hit_b_nxt;
    end
    if (emit) begin
      out_rgb_r  <= out_rgb_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MODE: prdata = {30'd0, mode_r};
      REG_GRAY: prdata = {31'd0, gray_r};
      default:  prdata = 32'd0;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_red         = out_rgb_r.red;
  assign out_green       = out_rgb_r.green;
  assign out_blue        = out_rgb_r.blue;
  assign out_last_of_run = out_last_r;

endmodule

>>> rtl/itpd_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the texture pixel decoder, and its bind to the top level.
// Depends only on the top level's port list.
module itpd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_action,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_red,
  input logic [7:0]  out_green,
  input logic [7:0]  out_blue,
  input logic        out_last_of_run,
  input logic        pready
);

  // The result channel is empty straight after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // The register port never inserts wait states.
  a_no_wait: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
      && $stable(out_blue) && $stable(out_last_of_run))
    else $error("stalled result changed");

  // After an accepted pixel item has passed the stage-1 register, a result is on offer.
  a_pixel_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action |-> ##2 out_valid)
    else $error("pixel item produced no result");

endmodule

bind indexed_texture_pixel_decoder itpd_checker u_itpd_checker (.*);

>>> bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for indexed_texture_pixel_decoder: a directed table, then random items.
// Pixels are checked against a local palette copy and colour decoder, or against table values.
// Depends on itpd_pkg and the decoder RTL.
module testbench;
  import itpd_pkg::*;

  localparam int PAL_DEPTH = 256;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 200;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 203;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_t;

  typedef struct {
    logic [1:0]  mode;
    logic        gray;
    logic        action;
    logic [7:0]  index;
    logic [15:0] word;
    bit          known;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last;
  } vector_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_action;
  logic [7:0]  in_palette_index;
  logic [15:0] in_data_word;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic        out_last_of_run;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pixel_t      expected_px[$];
  logic [14:0] pal_mirror [PAL_DEPTH];
  logic [1:0]  cur_mode;
  logic        cur_gray;
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;

  vector_t directed_vecs [25] = '{
    '{MODE_8BIT,   1'b0, ACT_PIXEL,     8'h00, 16'h0000, 1'b1, 8'h00, 8'h00, 8'h00, 1'b1},
    '{MODE_8BIT,   1'b0, ACT_PIXEL,     8'hFF, 16'hFFFF, 1'b1, 8'h00, 8'h00, 8'h00, 1'b1},
    '{MODE_8BIT,   1'b0, ACT_PAL_WRITE, 8'hFF, 16'hFFFF, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{MODE_8BIT,   1'b0, ACT_PIXEL,     8'h00, 16'hAAFF, 1'b1, 8'hF8, 8'hF8, 8'hF8, 1'b1},
    '{MODE_8BIT,   1'b0, ACT_PAL_WRITE, 8'h00, 16'h8000, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{MODE_8BIT,   1'b0, ACT_PIXEL,     8'h00, 16'h0000, 1'b1, 8'h00, 8'h00, 8'h00, 1'b1},
    '{MODE_8BIT,   1'b0, ACT_PAL_WRITE, 8'h01, 16'h7C00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{MODE_8BIT,   1'b0, ACT_PAL_WRITE, 8'h02, 16'h03E0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{MODE_8BIT,   1'b0, ACT_PAL_WRITE, 8'h03, 16'h001F, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{MODE_8BIT,   1'b0, ACT_PIXEL,     8'h00, 16'h0001, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{MODE_8BIT,   1'b0, ACT_PIXEL,     8'h00, 16'h5502, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{MODE_8BIT,   1'b0, ACT_PIXEL,     8'h00, 16'h0003, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{MODE_4BIT,   1'b0, ACT_PIXEL,     8'h00, 16'hFF12, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{MODE_4BIT,   1'b0, ACT_PIXEL,     8'hFF, 16'h00F0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{MODE_DIRECT, 1'b0, ACT_PIXEL,     8'h00, 16'hFFFF, 1'b1, 8'hF8, 8'hF8, 8'hF8, 1'b1},
    '{MODE_DIRECT, 1'b0, ACT_PIXEL,     8'hFF, 16'h0000, 1'b1, 8'h00, 8'h00, 8'h00, 1'b1},
    '{MODE_DIRECT, 1'b0, ACT_PIXEL,     8'h00, 16'h8000, 1'b1, 8'h00, 8'h00, 8'h00, 1'b1},
    '{MODE_UNUSED, 1'b0, ACT_PIXEL,     8'h00, 16'h7C00, 1'b1, 8'hF8, 8'h00, 8'h00, 1'b1},
    '{MODE_8BIT,   1'b1, ACT_PIXEL,     8'h00, 16'h0000, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b1},
    '{MODE_8BIT,   1'b1, ACT_PIXEL,     8'h00, 16'h00FF, 1'b1, 8'h01, 8'h01, 8'h01, 1'b1},
    '{MODE_8BIT,   1'b1, ACT_PAL_WRITE, 8'h10, 16'h1234, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{MODE_4BIT,   1'b1, ACT_PIXEL,     8'h00, 16'h00F0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{MODE_8BIT,   1'b0, ACT_PIXEL,     8'h00, 16'h0010, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{MODE_4BIT,   1'b1, ACT_PIXEL,     8'h00, 16'h0F0F, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{MODE_DIRECT, 1'b1, ACT_PIXEL,     8'h00, 16'h1234, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0}
  };

  logic [1:0] phase_modes [RANDOM_PHASES] = '{MODE_4BIT, MODE_DIRECT, MODE_8BIT, MODE_4BIT,
                                              MODE_UNUSED, MODE_8BIT, MODE_DIRECT, MODE_UNUSED};
  logic       phase_grays [RANDOM_PHASES] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};

  indexed_texture_pixel_decoder #(
    .PALETTE_DEPTH(PAL_DEPTH)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_palette_index (in_palette_index),
    .in_data_word     (in_data_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_last_of_run  (out_last_of_run),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #5 clk = ~clk;

  function automatic pixel_t widen555(logic [14:0] c, logic last);
    pixel_t p;
    p.red   = {c[14:10], 3'b000};
    p.green = {c[9:5], 3'b000};
    p.blue  = {c[4:0], 3'b000};
    p.last  = last;
    return p;
  endfunction

  function automatic pixel_t palette_colour(int unsigned i, int unsigned n, logic last);
    pixel_t     p;
    logic [7:0] g;
    if (cur_gray) begin
      g = 8'(255 - (i * 255) / n);
      p = '{g, g, g, last};
    end else if (i < PAL_DEPTH) begin
      p = widen555(pal_mirror[8'(i)], last);
    end else begin
      p = '{8'h00, 8'h00, 8'h00, last};
    end
    return p;
  endfunction

  task automatic decode_item(logic action, logic [7:0] idx, logic [15:0] word);
    if (action == ACT_PAL_WRITE) begin
      if (idx < PAL_DEPTH) pal_mirror[idx] = word[14:0];
    end else begin
      case (cur_mode)
        MODE_4BIT: begin
          expected_px.push_back(palette_colour(32'(word[7:4]), 16, 1'b0));
          expected_px.push_back(palette_colour(32'(word[3:0]), 16, 1'b1));
        end
        MODE_8BIT: begin
          expected_px.push_back(palette_colour(32'(word[7:0]), 256, 1'b1));
        end
        default: begin
          expected_px.push_back(widen555(word[14:0], 1'b1));
        end
      endcase
    end
  endtask

  task automatic send_item(logic action, logic [7:0] idx, logic [15:0] word);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 12) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_action        <= action;
    in_palette_index <= idx;
    in_data_word     <= word;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  task automatic drain_pixels();
    in_valid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The bus is left selected between the two writes; set_register lowers it afterwards.
  task automatic cfg_write(logic sel, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (sel == REG_MODE) cur_mode = data[1:0];
    else cur_gray = data[0];
  endtask

  task automatic set_register(logic [1:0] m, logic g);
    drain_pixels();
    cfg_write(REG_MODE, ($urandom() & ~32'h3) | 32'(m));
    cfg_write(REG_GRAY, ($urandom() & ~32'h1) | 32'(g));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int unsigned wait_cycles;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        wait_cycles = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        wait_cycles = rx_idle ? $urandom_range(0, 12) : 0;
      end
      if (wait_cycles != 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  always @(posedge clk) begin
    pixel_t want;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (expected_px.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("Unexpected pixel: r=%h g=%h b=%h last=%b",
                     out_red, out_green, out_blue, out_last_of_run);
        end else begin
          want = expected_px.pop_front();
          if (out_red !== want.red || out_green !== want.green ||
              out_blue !== want.blue || out_last_of_run !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"Pixel mismatch: expected r=%h g=%h b=%h last=%b, ",
                        "got r=%h g=%h b=%h last=%b"},
                       want.red, want.green, want.blue, want.last,
                       out_red, out_green, out_blue, out_last_of_run);
          end
        end
      end
    end
  end

  initial begin
    vector_t     v;
    logic        act;
    logic [7:0]  idx;
    logic [15:0] word;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_action        <= 1'b0;
    in_palette_index <= 8'h00;
    in_data_word     <= 16'h0000;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= 3'b000;
    pwdata           <= 32'h0;
    cur_mode = MODE_8BIT;
    cur_gray = 1'b0;
    foreach (pal_mirror[k]) pal_mirror[k] = 15'h0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_vecs[k]) begin
      v = directed_vecs[k];
      if (v.mode !== cur_mode || v.gray !== cur_gray) set_register(v.mode, v.gray);
      if (v.known) expected_px.push_back('{v.red, v.green, v.blue, v.last});
      else decode_item(v.action, v.index, v.word);
      send_item(v.action, v.index, v.word);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_register(phase_modes[p], phase_grays[p]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 50 == 0) begin
          tx_idle = ($urandom_range(0, 3) != 0);
          rx_idle = ($urandom_range(0, 3) != 0);
        end
        // Hold the output back while items keep arriving back to back, so the block backs up.
        if (p == 0 && n == 60) begin
          hold_req = 1'b1;
          tx_idle  = 1'b0;
        end
        act = ($urandom_range(0, 99) < 20) ? ACT_PAL_WRITE : ACT_PIXEL;
        if (cur_mode == MODE_4BIT && $urandom_range(0, 1) == 1)
          idx = 8'($urandom_range(0, 15));
        else
          idx = 8'($urandom_range(0, 255));
        word = 16'($urandom_range(0, 65535));
        decode_item(act, idx, word);
        send_item(act, idx, word);
      end
    end

    drain_pixels();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/itpd_pkg.sv
rtl/itpd_ram.sv
rtl/indexed_texture_pixel_decoder.sv
rtl/itpd_checker.sv
bench/testbench.sv
